// ----- src/ctt_pkg.sv -----
// Shared types and constants for the thresholded centroid tracker.
`default_nettype none
package ctt_pkg;

  localparam int unsigned PixW    = 8;
  localparam int unsigned SizeW   = 12;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned SumW    = 33;
  localparam int unsigned TallyW  = 23;
  localparam int unsigned CentW   = 11;
  localparam int unsigned FifoDepth = 4;

  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxHeight = 2048;

  localparam logic [PixW-1:0]  ThresholdRst   = 8'd128;
  localparam logic [SizeW-1:0] FrameWidthRst  = 12'd1280;
  localparam logic [SizeW-1:0] FrameHeightRst = 12'd720;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgThreshold   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd2;

  // One classified pixel on its way from front to back
  typedef struct packed {
    logic              on;
    logic              done;
    logic [SumW-1:0]   sum_x;
    logic [SumW-1:0]   sum_y;
    logic [TallyW-1:0] tally;
  } ctt_item_t;

  // Queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } ctt_q_stat_t;

endpackage
`default_nettype wire

// ----- src/ctt_front.sv -----
// Front end: configuration, thresholding, position tracking and accumulation.
`default_nettype none
module ctt_front #(
  parameter int unsigned MaxWidth  = ctt_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = ctt_pkg::DefMaxHeight
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ctt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ctt_pkg::SizeW-1:0]    cfg_data_i,
  input  logic                         push_i,
  input  logic [ctt_pkg::PixW-1:0]     red_i,
  input  logic [ctt_pkg::PixW-1:0]     green_i,
  input  logic [ctt_pkg::PixW-1:0]     blue_i,
  output ctt_pkg::ctt_item_t           item_o
);
  import ctt_pkg::*;

  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned RW = $clog2(MaxHeight);

  logic [PixW-1:0]   thr_q;
  logic [SizeW-1:0]  fw_q, fh_q;
  logic [CW-1:0]     col_q, col_d, col_last;
  logic [RW-1:0]     row_q, row_d, row_last;
  logic [SumW-1:0]   sum_x_q, sum_y_q, sum_x_nxt, sum_y_nxt;
  logic [TallyW-1:0] tally_q, tally_nxt;
  logic [PixW-1:0]   bright;
  logic [31:0]       fw_ext, fh_ext, wlast32, hlast32;
  logic              on, at_col_end, at_row_end, done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThresholdRst;
      fw_q  <= FrameWidthRst;
      fh_q  <= FrameHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold:   thr_q <= cfg_data_i[PixW-1:0];
        CfgFrameWidth:  fw_q  <= cfg_data_i;
        CfgFrameHeight: fh_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Last position: a zero size acts as one, a large one saturates
  assign fw_ext = 32'(fw_q);
  assign fh_ext = 32'(fh_q);

  always_comb begin
    if (fw_ext == 32'd0) begin
      wlast32 = 32'd0;
    end else if (fw_ext > 32'(MaxWidth)) begin
      wlast32 = 32'(MaxWidth) - 32'd1;
    end else begin
      wlast32 = fw_ext - 32'd1;
    end
    if (fh_ext == 32'd0) begin
      hlast32 = 32'd0;
    end else if (fh_ext > 32'(MaxHeight)) begin
      hlast32 = 32'(MaxHeight) - 32'd1;
    end else begin
      hlast32 = fh_ext - 32'd1;
    end
  end

  assign col_last = wlast32[CW-1:0];
  assign row_last = hlast32[RW-1:0];

  always_comb begin
    bright = red_i;
    if (green_i > bright) bright = green_i;
    if (blue_i > bright)  bright = blue_i;
  end

  assign on         = bright > thr_q;
  assign at_col_end = col_q >= col_last;
  assign at_row_end = row_q >= row_last;
  assign done       = at_col_end && at_row_end;

  assign sum_x_nxt = on ? sum_x_q + SumW'(col_q) : sum_x_q;
  assign sum_y_nxt = on ? sum_y_q + SumW'(row_q) : sum_y_q;
  assign tally_nxt = on ? tally_q + TallyW'(1)   : tally_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (at_col_end) begin
      col_d = '0;
      row_d = at_row_end ? '0 : row_q + RW'(1);
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      tally_q <= '0;
    end else if (push_i) begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_x_q <= done ? '0 : sum_x_nxt;
      sum_y_q <= done ? '0 : sum_y_nxt;
      tally_q <= done ? '0 : tally_nxt;
    end
  end

  assign item_o.on    = on;
  assign item_o.done  = done;
  assign item_o.sum_x = sum_x_nxt;
  assign item_o.sum_y = sum_y_nxt;
  assign item_o.tally = tally_nxt;

endmodule
`default_nettype wire

// ----- src/ctt_fifo.sv -----
// Short queue of classified pixels between front and back.
`default_nettype none
module ctt_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ctt_pkg::ctt_item_t   item_i,
  input  logic                 pop_i,
  output ctt_pkg::ctt_item_t   item_o,
  output ctt_pkg::ctt_q_stat_t stat_o
);
  import ctt_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  ctt_item_t       mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrW'(FifoDepth - 1)) ? '0 : rd_q + PtrW'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == CntW'(FifoDepth);
  assign stat_o.empty = cnt_q == '0;

endmodule
`default_nettype wire

// ----- src/ctt_back.sv -----
// Back end: centroid division at frame end and the output register.
`default_nettype none
module ctt_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  ctt_pkg::ctt_item_t          item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        binary_pixel_o,
  output logic                        frame_done_o,
  output logic [ctt_pkg::CentW-1:0]   centroid_x_o,
  output logic [ctt_pkg::CentW-1:0]   centroid_y_o,
  output logic                        centroid_valid_o,
  output logic [ctt_pkg::TallyW-1:0]  bright_count_o
);
  import ctt_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;
  localparam int unsigned StepW = $clog2(SumW);

  logic [1:0]        state_q, state_d;
  logic [StepW-1:0]  step_q;
  logic [SumW-1:0]   qx_q, qy_q;
  logic [TallyW-1:0] rx_q, ry_q, div_q;
  logic              on_q;
  logic [TallyW:0]   shx, shy;
  logic              gex, gey;
  logic              slot_free, load_out, need_div;

  logic              out_valid_q;
  logic              bin_q, done_q, cval_q;
  logic [CentW-1:0]  cx_q, cy_q;
  logic [TallyW-1:0] cnt_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign need_div  = item_i.done && (item_i.tally != '0);
  assign pop_o     = (state_q == StIdle) && q_valid_i && slot_free;

  // One restoring division step per cycle for both axes
  assign shx = {rx_q, qx_q[SumW-1]};
  assign shy = {ry_q, qy_q[SumW-1]};
  assign gex = shx >= {1'b0, div_q};
  assign gey = shy >= {1'b0, div_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (pop_o && need_div) state_d = StDiv;
      StDiv:   if (step_q == StepW'(SumW - 1)) state_d = StOut;
      StOut:   if (slot_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StDiv) step_q <= step_q + StepW'(1);
      else                  step_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      on_q  <= item_i.on;
      qx_q  <= item_i.sum_x;
      qy_q  <= item_i.sum_y;
      div_q <= item_i.tally;
      rx_q  <= '0;
      ry_q  <= '0;
    end else if (state_q == StDiv) begin
      qx_q <= {qx_q[SumW-2:0], gex};
      qy_q <= {qy_q[SumW-2:0], gey};
      rx_q <= gex ? TallyW'(shx - {1'b0, div_q}) : shx[TallyW-1:0];
      ry_q <= gey ? TallyW'(shy - {1'b0, div_q}) : shy[TallyW-1:0];
    end
  end

  assign load_out = (pop_o && !need_div) || ((state_q == StOut) && slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && !need_div) begin
      bin_q  <= item_i.on;
      done_q <= item_i.done;
      cx_q   <= '0;
      cy_q   <= '0;
      cval_q <= 1'b0;
      cnt_q  <= '0;
    end else if ((state_q == StOut) && slot_free) begin
      bin_q  <= on_q;
      done_q <= 1'b1;
      cx_q   <= qx_q[CentW-1:0];
      cy_q   <= qy_q[CentW-1:0];
      cval_q <= 1'b1;
      cnt_q  <= div_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign binary_pixel_o   = bin_q;
  assign frame_done_o     = done_q;
  assign centroid_x_o     = cx_q;
  assign centroid_y_o     = cy_q;
  assign centroid_valid_o = cval_q;
  assign bright_count_o   = cnt_q;

endmodule
`default_nettype wire

// ----- src/thresholded_centroid_tracker.sv -----
// Top level of the thresholded centroid tracker: front, queue and back.
// Path: a plain result passes the queue entry and then the output register; a
//   frame's last pixel with bright pixels also runs 33 division steps first.
// Throughput: one pixel per cycle while the queue has room; a frame end with
//   bright pixels busies the divider; the 4-entry queue fills, input stalls.
// Reset: threshold 128, frame 1280 x 720, position and sums zero.
`default_nettype none
module thresholded_centroid_tracker #(
  parameter int unsigned MaxWidth  = ctt_pkg::DefMaxWidth,
  parameter int unsigned MaxHeight = ctt_pkg::DefMaxHeight
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [ctt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ctt_pkg::SizeW-1:0]   cfg_data_i,
  // pixel input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ctt_pkg::PixW-1:0]    red_i,
  input  logic [ctt_pkg::PixW-1:0]    green_i,
  input  logic [ctt_pkg::PixW-1:0]    blue_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        binary_pixel_o,
  output logic                        frame_done_o,
  output logic [ctt_pkg::CentW-1:0]   centroid_x_o,
  output logic [ctt_pkg::CentW-1:0]   centroid_y_o,
  output logic                        centroid_valid_o,
  output logic [ctt_pkg::TallyW-1:0]  bright_count_o
);
  import ctt_pkg::*;

  ctt_item_t   front_item, head_item;
  ctt_q_stat_t q_stat;
  logic        push, pop;

  // Take a pixel whenever the queue has room; the front is pure logic
  // plus counters and commits its state on the same transfer.
  assign in_ready_o = !q_stat.full;
  assign push       = in_valid_i && in_ready_o;

  ctt_front #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push_i    (push),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .item_o    (front_item)
  );

  // Decouple the frame-end division from the pixel stream
  ctt_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(front_item),
    .pop_i (pop),
    .item_o(head_item),
    .stat_o(q_stat)
  );

  // Back end drains the queue: plain pixels pass straight to the output
  // register, frame-end entries with a nonzero count run the divider first.
  ctt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (!q_stat.empty),
    .item_i          (head_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .binary_pixel_o  (binary_pixel_o),
    .frame_done_o    (frame_done_o),
    .centroid_x_o    (centroid_x_o),
    .centroid_y_o    (centroid_y_o),
    .centroid_valid_o(centroid_valid_o),
    .bright_count_o  (bright_count_o)
  );

  // A valid centroid only ever comes with a frame-end result
  a_cval_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && centroid_valid_o |-> frame_done_o)
    else $error("centroid_valid without frame_done");

  // A valid centroid carries a nonzero count
  a_cval_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && centroid_valid_o |-> bright_count_o != '0)
    else $error("centroid_valid with zero count");

  // Non frame-end results carry zero statistics
  a_plain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |->
      centroid_x_o == '0 && centroid_y_o == '0 && bright_count_o == '0)
    else $error("statistics on a plain pixel result");

  // Never pop an empty queue or push a full one
  a_queue_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_stat.empty) && !(push && q_stat.full))
    else $error("queue overflow or underflow");

endmodule
`default_nettype wire
